[rtl/core/cclt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cclt_pkg: types and codes for the cache line coherence transition block
// Holds the event, line state, snoop and outcome codes and the beat structs.
// ----------------------------------------------------------------------------
package cclt_pkg;

	// event codes
	localparam logic [2:0] OP_READ     = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_SNOOP    = 3'd2;
	localparam logic [2:0] OP_COMPLETE = 3'd3;
	localparam logic [2:0] OP_EVICT    = 3'd4;

	// line states: five stable, ten transient
	localparam logic [3:0] ST_I     = 4'd0;
	localparam logic [3:0] ST_UC    = 4'd1;
	localparam logic [3:0] ST_UD    = 4'd2;
	localparam logic [3:0] ST_SC    = 4'd3;
	localparam logic [3:0] ST_SD    = 4'd4;
	localparam logic [3:0] ST_UC_I  = 4'd5;
	localparam logic [3:0] ST_UD_I  = 4'd6;
	localparam logic [3:0] ST_SC_I  = 4'd7;
	localparam logic [3:0] ST_SD_I  = 4'd8;
	localparam logic [3:0] ST_I_UC  = 4'd9;
	localparam logic [3:0] ST_I_UD  = 4'd10;
	localparam logic [3:0] ST_I_SC  = 4'd11;
	localparam logic [3:0] ST_I_SD  = 4'd12;
	localparam logic [3:0] ST_UC_SC = 4'd13;
	localparam logic [3:0] ST_UD_SD = 4'd14;

	// snoop kinds as carried in the snoop_kind field
	localparam logic [3:0] SNP_ONCE          = 4'd0;
	localparam logic [3:0] SNP_SHARED        = 4'd1;
	localparam logic [3:0] SNP_CLEAN         = 4'd2;
	localparam logic [3:0] SNP_DATA          = 4'd3;
	localparam logic [3:0] SNP_CLEAN_SHARED  = 4'd4;
	localparam logic [3:0] SNP_CLEAN_INVALID = 4'd5;
	localparam logic [3:0] SNP_MAKE_INVALID  = 4'd6;
	localparam logic [3:0] SNP_STASH_UNIQUE  = 4'd7;
	localparam logic [3:0] SNP_STASH_SHARED  = 4'd8;

	// read/write outcome
	localparam logic [1:0] OUTC_COMPLETE = 2'd0;
	localparam logic [1:0] OUTC_PENDING  = 2'd1;
	localparam logic [1:0] OUTC_BLOCKED  = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] line_state;
		logic       ask_unique;
		logic [3:0] snoop_kind;
		logic       granted_unique;
		logic       granted_dirty;
	} cclt_req_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic [3:0] next_state;
		logic       sends_data;
		logic       data_dirty;
		logic       is_ack;
		logic       evicted;
		logic       needs_writeback;
	} cclt_rsp_t;

	// snoop response shape handed from the snoop table to the evaluator
	typedef struct packed {
		logic [3:0] next_state;
		logic       sends_data;
		logic       data_dirty;
	} cclt_snp_t;

endpackage

[rtl/core/cclt_snoop.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cclt_snoop: snoop response table
// Maps a line state and snoop kind to the next state and data response.
// ----------------------------------------------------------------------------
module cclt_snoop
	import cclt_pkg::*;
(
	input  logic [3:0] line_state,
	input  logic [3:0] snoop_kind,
	output cclt_snp_t  snp
);

	// per-state properties, one bit per state code
	localparam logic [15:0] MASK_DIRTY  = 16'b0101_0101_0101_0100;
	localparam logic [15:0] MASK_UNIQUE = 16'b0000_0110_0110_0110;
	localparam logic [15:0] MASK_SUPPLY = 16'b0000_0001_0111_0110;

	logic sup;
	logic dty;
	logic unq;

	assign sup = MASK_SUPPLY[line_state];
	assign dty = MASK_DIRTY[line_state];
	assign unq = MASK_UNIQUE[line_state];

	always_comb begin
		snp.next_state = line_state;
		snp.sends_data = 1'b0;
		snp.data_dirty = 1'b0;
		case (snoop_kind)
			SNP_ONCE: begin
				if (sup) begin
					snp.sends_data = 1'b1;
					snp.data_dirty = dty;
				end
			end
			SNP_SHARED: begin
				if (line_state == ST_UC) begin
					snp.sends_data = 1'b1;
					snp.next_state = ST_SC;
				end else if (line_state == ST_UD) begin
					snp.sends_data = 1'b1;
					snp.data_dirty = 1'b1;
					snp.next_state = ST_SD;
				end else if (!(line_state inside {ST_SC, ST_SD})) begin
					snp.next_state = ST_I;
				end
			end
			SNP_CLEAN, SNP_DATA: begin
				if (sup) begin
					snp.sends_data = 1'b1;
					snp.data_dirty = dty;
					if (dty) begin
						snp.next_state = ST_SD;
					end else if (unq) begin
						snp.next_state = ST_SC;
					end
				end
			end
			SNP_CLEAN_SHARED: begin
				if (line_state inside {ST_UD, ST_SD}) begin
					snp.sends_data = 1'b1;
					snp.data_dirty = 1'b1;
					snp.next_state = ST_SC;
				end else if (line_state == ST_UC) begin
					snp.sends_data = 1'b1;
					snp.next_state = ST_SC;
				end else if (line_state != ST_SC) begin
					snp.next_state = ST_I;
				end
			end
			SNP_CLEAN_INVALID, SNP_MAKE_INVALID: begin
				if (line_state inside {ST_UD, ST_SD}) begin
					snp.sends_data = 1'b1;
					snp.data_dirty = 1'b1;
				end else if (line_state == ST_UC) begin
					snp.sends_data = 1'b1;
				end
				snp.next_state = ST_I;
			end
			default: begin
				// stash and unknown kinds: plain ack, no change
			end
		endcase
	end

endmodule

[rtl/core/cclt_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cclt_eval: coherence transition evaluator
// Decides next state, outcome, snoop and eviction fields for one event.
// ----------------------------------------------------------------------------
module cclt_eval
	import cclt_pkg::*;
(
	input  cclt_req_t req,
	output cclt_rsp_t rsp
);

	logic [3:0] st;
	cclt_snp_t  snp;

	// state code 15 behaves as I
	assign st = (req.line_state > ST_UD_SD) ? ST_I : req.line_state;

	cclt_snoop u_snoop (
		.line_state (st),
		.snoop_kind (req.snoop_kind),
		.snp        (snp)
	);

	always_comb begin
		rsp                 = '0;
		rsp.next_state      = st;
		case (req.op)
			OP_READ: begin
				if (st == ST_I) begin
					rsp.outcome    = OUTC_PENDING;
					rsp.next_state = req.ask_unique ? ST_I_UC : ST_I_SC;
				end else if (st inside {ST_UC, ST_UD}) begin
					rsp.outcome = OUTC_COMPLETE;
				end else if (st inside {ST_SC, ST_SD}) begin
					rsp.outcome = req.ask_unique ? OUTC_PENDING : OUTC_COMPLETE;
				end else begin
					rsp.outcome = OUTC_BLOCKED;
				end
			end
			OP_WRITE: begin
				if (st == ST_I) begin
					rsp.outcome    = OUTC_PENDING;
					rsp.next_state = ST_I_UD;
				end else if (st inside {ST_UC, ST_UD}) begin
					rsp.outcome    = OUTC_COMPLETE;
					rsp.next_state = ST_UD;
				end else if (st inside {ST_SC, ST_SD}) begin
					rsp.outcome = OUTC_PENDING;
				end else begin
					rsp.outcome = OUTC_BLOCKED;
				end
			end
			OP_SNOOP: begin
				rsp.next_state = snp.next_state;
				rsp.sends_data = snp.sends_data;
				rsp.data_dirty = snp.data_dirty;
				rsp.is_ack     = !snp.sends_data;
			end
			OP_COMPLETE: begin
				case (st)
					ST_I_UC:                           rsp.next_state = ST_UC;
					ST_I_UD:                           rsp.next_state = ST_UD;
					ST_I_SC, ST_UC_SC:                 rsp.next_state = ST_SC;
					ST_I_SD, ST_UD_SD:                 rsp.next_state = ST_SD;
					ST_UC_I, ST_UD_I, ST_SC_I, ST_SD_I: rsp.next_state = ST_I;
					ST_SC, ST_SD: begin
						// upgrade completes only when ownership is granted
						if (req.granted_unique) begin
							rsp.next_state = req.granted_dirty ? ST_UD : ST_UC;
						end
					end
					default: begin
					end
				endcase
			end
			OP_EVICT: begin
				if (st inside {[ST_UC:ST_SD]}) begin
					rsp.next_state      = ST_I;
					rsp.evicted         = 1'b1;
					rsp.needs_writeback = (st inside {ST_UD, ST_SD});
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/cache_line_coherence_transition.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_line_coherence_transition: coherence state decision for one line
// Takes one event beat per cycle when not stalled and returns one decision beat per event.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries one event beat:
//   event code, current line state and the event qualifiers.
//   Response channel (rsp_valid / rsp_stall / rsp) returns one decision beat
//   per event: next state, read/write outcome, snoop response shape and
//   eviction result.
//   Path: a beat accepted into the input register is looked up into the
//   result register and can be taken from there (input register, then
//   result register). Throughput: one beat per cycle when not stalled,
//   bounded by the single table lookup between the two registers.
//   Stall: a stalled response holds in the result register; the input
//   register keeps taking beats until it too is full, then req_stall rises.
//   Reset: both valid flags clear, nothing is in flight, req_stall is low.
// ----------------------------------------------------------------------------
module cache_line_coherence_transition
	import cclt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  cclt_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output cclt_rsp_t rsp
);

	logic      valid_s1;
	cclt_req_t req_s1;
	logic      valid_s2;
	cclt_rsp_t rsp_s2;
	cclt_rsp_t rsp_next;
	logic      adv_s2;
	logic      adv_s1;

	// advance the result register when it is empty or being taken
	assign adv_s2 = !valid_s2 || !rsp_stall;
	// input register frees up when empty or when its beat moves on
	assign adv_s1 = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;

	cclt_eval u_eval (
		.req (req_s1),
		.rsp (rsp_next)
	);

	// valid flags: control state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload: load only on advance, hold while stalled
	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

[tb/sv/tb_cache_line_coherence_transition.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cache_line_coherence_transition: self-checking bench for the line
// coherence decision block
// Drives event beats through the valid/stall request channel, predicts each
// decision from the event alone, and compares every response beat in order.
// A short directed list hits each event, each snoop kind and the corner codes.
// A long random walk follows, feeding predicted next states back as the
// current state. Bursty sender, patterned receiver stalls, one long hold-off.
// ----------------------------------------------------------------------------
module tb_cache_line_coherence_transition
	import cclt_pkg::*;
;

	// codes outside the defined sets
	localparam logic [3:0] SNP_CODE_HI = 4'd15;
	localparam logic [2:0] OP_CODE_HI  = 3'd7;
	localparam logic [3:0] ST_CODE_HI  = 4'd15;

	localparam int RANDOM_EVENTS = 1450;
	localparam int HOLD_AFTER    = 400;     // beats noted before the long hold-off
	localparam int HOLD_CYCLES   = 160;
	localparam int DRAIN_CYCLES  = 6;       // two register stages plus margin
	localparam int RUN_LIMIT_NS  = 5000000;

	// ------------------------------------------------------------------------
	// Decision predictor and in-order store of expected response beats
	// ------------------------------------------------------------------------
	class coherence_checker;
		cclt_rsp_t   expected_q[$];
		int unsigned events_noted;
		int unsigned mismatch_count;

		function bit is_dirty(logic [3:0] st);
			case (st)
				ST_UD, ST_SD, ST_UD_I, ST_SD_I, ST_I_UD, ST_I_SD, ST_UD_SD: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function bit is_unique(logic [3:0] st);
			case (st)
				ST_UC, ST_UD, ST_UC_I, ST_UD_I, ST_I_UC, ST_I_UD: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function bit can_supply(logic [3:0] st);
			case (st)
				ST_UC, ST_UD, ST_SD, ST_UC_I, ST_UD_I, ST_SD_I: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		// next state and response shape for one event
		function cclt_rsp_t decide(cclt_req_t ev);
			cclt_rsp_t  d;
			logic [3:0] st;
			logic       data;
			logic       dirty;
			// an out-of-range state code reads as I
			st = (ev.line_state > ST_UD_SD) ? ST_I : ev.line_state;
			d = '0;
			d.next_state = st;
			data = 1'b0;
			dirty = 1'b0;
			case (ev.op)
				OP_READ: begin
					if (st == ST_I) begin
						d.outcome = OUTC_PENDING;
						d.next_state = ev.ask_unique ? ST_I_UC : ST_I_SC;
					end else if (st == ST_UC || st == ST_UD) begin
						d.outcome = OUTC_COMPLETE;
					end else if (st == ST_SC || st == ST_SD) begin
						d.outcome = ev.ask_unique ? OUTC_PENDING : OUTC_COMPLETE;
					end else begin
						d.outcome = OUTC_BLOCKED;
					end
				end
				OP_WRITE: begin
					if (st == ST_I) begin
						d.outcome = OUTC_PENDING;
						d.next_state = ST_I_UD;
					end else if (st == ST_UC || st == ST_UD) begin
						d.outcome = OUTC_COMPLETE;
						d.next_state = ST_UD;
					end else if (st == ST_SC || st == ST_SD) begin
						d.outcome = OUTC_PENDING;
					end else begin
						d.outcome = OUTC_BLOCKED;
					end
				end
				OP_SNOOP: begin
					case (ev.snoop_kind)
						SNP_ONCE: begin
							if (can_supply(st)) begin
								data = 1'b1;
								dirty = is_dirty(st);
							end
						end
						SNP_SHARED: begin
							if (st == ST_UC) begin
								data = 1'b1;
								d.next_state = ST_SC;
							end else if (st == ST_UD) begin
								data = 1'b1;
								dirty = 1'b1;
								d.next_state = ST_SD;
							end else if (st != ST_SC && st != ST_SD) begin
								d.next_state = ST_I;
							end
						end
						SNP_CLEAN, SNP_DATA: begin
							if (can_supply(st)) begin
								data = 1'b1;
								dirty = is_dirty(st);
								if (is_dirty(st))
									d.next_state = ST_SD;
								else if (is_unique(st))
									d.next_state = ST_SC;
							end
						end
						SNP_CLEAN_SHARED: begin
							if (st == ST_UD || st == ST_SD) begin
								data = 1'b1;
								dirty = 1'b1;
								d.next_state = ST_SC;
							end else if (st == ST_UC) begin
								data = 1'b1;
								d.next_state = ST_SC;
							end else if (st != ST_SC) begin
								d.next_state = ST_I;
							end
						end
						SNP_CLEAN_INVALID, SNP_MAKE_INVALID: begin
							if (st == ST_UD || st == ST_SD) begin
								data = 1'b1;
								dirty = 1'b1;
							end else if (st == ST_UC) begin
								data = 1'b1;
							end
							d.next_state = ST_I;
						end
						default: ;  // stash and unknown kinds: plain ack
					endcase
					d.sends_data = data;
					d.data_dirty = dirty;
					d.is_ack = !data;
				end
				OP_COMPLETE: begin
					case (st)
						ST_I_UC: d.next_state = ST_UC;
						ST_I_UD: d.next_state = ST_UD;
						ST_I_SC, ST_UC_SC: d.next_state = ST_SC;
						ST_I_SD, ST_UD_SD: d.next_state = ST_SD;
						ST_UC_I, ST_UD_I, ST_SC_I, ST_SD_I: d.next_state = ST_I;
						ST_SC, ST_SD: begin
							if (ev.granted_unique)
								d.next_state = ev.granted_dirty ? ST_UD : ST_UC;
						end
						default: ;
					endcase
				end
				OP_EVICT: begin
					if (st >= ST_UC && st <= ST_SD) begin
						d.next_state = ST_I;
						d.evicted = 1'b1;
						d.needs_writeback = (st == ST_UD || st == ST_SD);
					end
				end
				default: ;
			endcase
			return d;
		endfunction

		function void note_event(cclt_req_t ev);
			events_noted++;
			expected_q.push_back(decide(ev));
		endfunction

		function void flag(string msg);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch: %0s", msg);
		endfunction

		function void check_decision(cclt_rsp_t got);
			cclt_rsp_t want;
			string     bad;
			bad = "";
			if (expected_q.size() == 0) begin
				flag($sformatf("response beat %h with none expected", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.outcome !== want.outcome) bad = {bad, " outcome"};
			if (got.next_state !== want.next_state) bad = {bad, " next_state"};
			if (got.sends_data !== want.sends_data) bad = {bad, " sends_data"};
			if (got.data_dirty !== want.data_dirty) bad = {bad, " data_dirty"};
			if (got.is_ack !== want.is_ack) bad = {bad, " is_ack"};
			if (got.evicted !== want.evicted) bad = {bad, " evicted"};
			if (got.needs_writeback !== want.needs_writeback) bad = {bad, " needs_writeback"};
			if (bad != "")
				flag($sformatf("fields%0s expected %h got %h", bad, want, got));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block
	// ------------------------------------------------------------------------
	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	cclt_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	cclt_rsp_t rsp;

	coherence_checker sb = new;
	bit long_hold;   // receiver is in its long hold-off
	bit hold_done;

	always #6 clk = ~clk;

	cache_line_coherence_transition u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------
	function automatic cclt_req_t make_event(logic [2:0] op, logic [3:0] st, bit wu,
			logic [3:0] kind, bit gu, bit gd);
		cclt_req_t ev;
		ev.op = op;
		ev.line_state = st;
		ev.ask_unique = wu;
		ev.snoop_kind = kind;
		ev.granted_unique = gu;
		ev.granted_dirty = gd;
		return ev;
	endfunction

	// Half the time continue from the last predicted state so the walk
	// passes through transient states and their completions; otherwise
	// jump anywhere in the full 4-bit code space.
	function automatic cclt_req_t random_event(logic [3:0] walk);
		cclt_req_t ev;
		if ($urandom_range(0, 9) == 0)
			ev.op = 3'($urandom_range(OP_EVICT + 1, OP_CODE_HI));
		else
			ev.op = 3'($urandom_range(OP_READ, OP_EVICT));
		if ($urandom_range(0, 1) == 1)
			ev.line_state = walk;
		else
			ev.line_state = 4'($urandom_range(ST_I, ST_CODE_HI));
		ev.ask_unique = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) == 0)
			ev.snoop_kind = 4'($urandom_range(SNP_ONCE, SNP_CODE_HI));
		else
			ev.snoop_kind = 4'($urandom_range(SNP_ONCE, SNP_STASH_SHARED));
		ev.granted_unique = 1'($urandom_range(0, 1));
		ev.granted_dirty = 1'($urandom_range(0, 1));
		return ev;
	endfunction

	// Offer one beat from the next falling edge and hold it until the edge
	// that takes it; valid stays high so a following beat goes back to back.
	task automatic send_event(cclt_req_t ev);
		@(negedge clk);
		req <= ev;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_event(ev);
	endtask

	// Drop valid for a number of cycles.
	task automatic pause_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------------
	// Check every response beat taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_decision(rsp);
	end

	// Stall in segments of random style: none, light random, a regular
	// pattern from the cycle count, heavy random. Once enough beats went in,
	// hold the stall for a long stretch so both registers fill and req_stall rises.
	initial begin
		int seg_mode;
		int seg_len;
		int cyc;
		rsp_stall = 1'b0;
		long_hold = 1'b0;
		hold_done = 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			seg_mode = $urandom_range(0, 3);
			seg_len = $urandom_range(20, 200);
			repeat (seg_len) begin
				@(negedge clk);
				cyc++;
				if (!hold_done && sb.events_noted >= HOLD_AFTER) begin
					long_hold = 1'b1;
					rsp_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					long_hold = 1'b0;
					hold_done = 1'b1;
					rsp_stall <= 1'b0;
				end else begin
					case (seg_mode)
						0: rsp_stall <= 1'b0;
						1: rsp_stall <= ($urandom_range(0, 99) < 30);
						2: rsp_stall <= (cyc % 4 == 3);
						default: rsp_stall <= ($urandom_range(0, 99) < 75);
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		cclt_req_t  directed_q[$];
		cclt_req_t  ev;
		cclt_rsp_t  peek;
		logic [3:0] walk;
		int         burst;
		int         sent;
		int         drain;

		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reads: miss shared and unique, hit unique, upgrade, blocked on transient
		directed_q.push_back(make_event(OP_READ, ST_I, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_READ, ST_I, 1'b1, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_READ, ST_UD, 1'b1, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_READ, ST_SC, 1'b1, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_READ, ST_SD_I, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		// writes: miss, hit, upgrade, blocked on transient
		directed_q.push_back(make_event(OP_WRITE, ST_I, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_WRITE, ST_UC, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_WRITE, ST_SD, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_WRITE, ST_I_SD, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		// every snoop kind, one on a transient state, one unknown kind
		directed_q.push_back(make_event(OP_SNOOP, ST_UD_I, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UC, 1'b0, SNP_SHARED, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UD, 1'b0, SNP_SHARED, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UC, 1'b0, SNP_CLEAN, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_SD, 1'b0, SNP_DATA, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UD, 1'b0, SNP_CLEAN_SHARED, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_SC, 1'b0, SNP_CLEAN_INVALID, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UD, 1'b0, SNP_MAKE_INVALID, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UC, 1'b0, SNP_STASH_UNIQUE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_SD, 1'b0, SNP_STASH_SHARED, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_SNOOP, ST_UD, 1'b0, SNP_CODE_HI, 1'b0, 1'b0));
		// completions: upgrade to dirty and clean unique, pending eviction, nothing pending
		directed_q.push_back(make_event(OP_COMPLETE, ST_SC, 1'b0, SNP_ONCE, 1'b1, 1'b1));
		directed_q.push_back(make_event(OP_COMPLETE, ST_SD, 1'b0, SNP_ONCE, 1'b1, 1'b0));
		directed_q.push_back(make_event(OP_COMPLETE, ST_UC_I, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_COMPLETE, ST_UD, 1'b0, SNP_ONCE, 1'b1, 1'b1));
		// evictions: dirty line, transient line
		directed_q.push_back(make_event(OP_EVICT, ST_UD, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		directed_q.push_back(make_event(OP_EVICT, ST_UC_I, 1'b0, SNP_ONCE, 1'b0, 1'b0));
		// unknown event code on the out-of-range state, every other bit high
		directed_q.push_back(make_event(OP_CODE_HI, ST_CODE_HI, 1'b1, SNP_CODE_HI, 1'b1, 1'b1));
		directed_q.push_back(make_event(OP_READ, ST_CODE_HI, 1'b1, SNP_CODE_HI, 1'b1, 1'b1));

		foreach (directed_q[i]) begin
			send_event(directed_q[i]);
			if ($urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 3));
		end

		// random walk in bursts; no gaps while the receiver holds off so the
		// block fills and backs up into the request channel
		walk = ST_I;
		sent = 0;
		while (sent < RANDOM_EVENTS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				ev = random_event(walk);
				peek = sb.decide(ev);
				walk = peek.next_state;
				send_event(ev);
				sent++;
			end
			if (!long_hold && $urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 6));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// drain what is still in flight, then wait out the DRAIN_CYCLES quiet margin
		while (sb.pending() != 0)
			@(posedge clk);
		drain = DRAIN_CYCLES;
		repeat (drain) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/core/cclt_pkg.sv
rtl/core/cclt_snoop.sv
rtl/core/cclt_eval.sv
rtl/core/cache_line_coherence_transition.sv
tb/sv/tb_cache_line_coherence_transition.sv
